[rtl/core/atrp_pkg.sv]
// Package: shared types, constants and ROM tables of the AT response parser.
`timescale 1ns / 1ps

package atrp_pkg;

    // Command codes (same encoding as the mode input)
    localparam logic [2:0] MODE_AT      = 3'd0;
    localparam logic [2:0] MODE_ATI     = 3'd1;
    localparam logic [2:0] MODE_CCID    = 3'd2;
    localparam logic [2:0] MODE_CPIN    = 3'd3;
    localparam logic [2:0] MODE_CSQ     = 3'd4;
    localparam logic [2:0] MODE_CREG    = 3'd5;
    localparam logic [2:0] MODE_CGATT   = 3'd6;
    localparam logic [2:0] MODE_SYSINFO = 3'd7;

    localparam int MAX_PAYLOAD = 64;
    localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int CAPTURE_W   = 6;

    localparam int TAIL_LEN = 6;
    localparam int HDR_MAX  = 16;
    localparam int HIDX_W   = $clog2(HDR_MAX);
    localparam int HLEN_W   = $clog2(HDR_MAX + 1);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // CR LF 'O' 'K' CR LF, padded to a power of two
    localparam logic [7:0] TAIL_ROM [0:7] = '{
        CH_CR, CH_LF, 8'h4F, 8'h4B, CH_CR, CH_LF, 8'h00, 8'h00
    };

    localparam logic [HLEN_W-1:0] HDR_LEN [0:7] = '{
        HLEN_W'(0), HLEN_W'(16), HLEN_W'(8), HLEN_W'(12),
        HLEN_W'(5), HLEN_W'(6),  HLEN_W'(7), HLEN_W'(13)
    };

    // Header bytes per command, unused slots zero
    localparam logic [7:0] HDR_ROM [0:7][0:HDR_MAX-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // ATI: identification banner
        '{8'h0D, 8'h0A, 8'h4E, 8'h45, 8'h4F, 8'h57, 8'h41, 8'h59,
          8'h0D, 8'h0A, 8'h4E, 8'h37, 8'h32, 8'h30, 8'h0D, 8'h0A},
        // CR LF "+CCID:"
        '{8'h0D, 8'h0A, 8'h2B, 8'h43, 8'h43, 8'h49, 8'h44, 8'h3A,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // "+CPIN:" CR LF "OK" CR LF
        '{8'h2B, 8'h43, 8'h50, 8'h49, 8'h4E, 8'h3A, 8'h0D, 8'h0A,
          8'h4F, 8'h4B, 8'h0D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
        // "+CSQ:"
        '{8'h2B, 8'h43, 8'h53, 8'h51, 8'h3A, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // "+CREG:"
        '{8'h2B, 8'h43, 8'h52, 8'h45, 8'h47, 8'h3A, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // "+CGATT:"
        '{8'h2B, 8'h43, 8'h47, 8'h41, 8'h54, 8'h54, 8'h3A, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        // CR LF "$MYSYSINFO:"
        '{8'h0D, 8'h0A, 8'h24, 8'h4D, 8'h59, 8'h53, 8'h59, 8'h53,
          8'h49, 8'h4E, 8'h46, 8'h4F, 8'h3A, 8'h00, 8'h00, 8'h00}
    };

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_TAIL    = 3'b100
    } phase_t;

endpackage

[rtl/core/at_response_parser_core.sv]
// AT response parser core: byte-wide recognizer of modem replies.
`timescale 1ns / 1ps

// One received byte per transaction; one result per byte. The block sustains
// one byte per clock while the result side keeps taking results (result_ready);
// a held result stalls it. A byte is held in an input register, runs through
// one header/tail ROM compare and the counter update, and lands in the result
// register once that is free or being emptied. The parse state (phase, header
// index, tail index, payload count) is updated as the result register loads,
// so the next byte sees it at once. Mode AT only hunts for the CR LF "OK" CR LF
// tail; other modes match their header, then emit payload bytes as indexed
// writes (capture_*) until a CR, then require the rest of the tail. A
// completed reply gives a single-result done_res pulse with the command code
// in done_command. Payload beyond MAX_PAYLOAD bytes is dropped silently.
module at_response_parser_core
    import atrp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [2:0]           mode,
    input  logic [7:0]           rx_byte,

    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 capture_valid,
    output logic [CAPTURE_W-1:0] capture_index,
    output logic [7:0]           capture_byte,
    output logic                 done_res,
    output logic [2:0]           done_command
);

    // input register
    logic       in_full_reg;
    logic [2:0] mode_reg;
    logic [7:0] byte_reg;

    // parse state
    phase_t              phase_reg,  phase_next;
    logic [HIDX_W-1:0]   head_reg,   head_next;
    logic [2:0]          tail_reg,   tail_next;
    logic [COUNT_W-1:0]  count_reg,  count_next;

    // result register
    logic                 out_valid_reg;
    logic                 cv_reg, cv_next;
    logic [CAPTURE_W-1:0] ci_reg, ci_next;
    logic [7:0]           cb_reg, cb_next;
    logic                 dr_reg, dr_next;
    logic [2:0]           dc_reg, dc_next;

    logic                advance;
    logic                tail_hit;
    logic                head_hit;
    logic [3:0]          tail_nxt;
    logic                tail_nxt_hit;

    // a held byte moves on when the result slot is free or being emptied
    assign advance    = in_full_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_full_reg || advance;

    assign tail_hit = ({1'b0, tail_reg} < 4'(TAIL_LEN)) && (TAIL_ROM[tail_reg] == byte_reg);
    assign head_hit = ({1'b0, head_reg} < HDR_LEN[mode_reg])
                   && (HDR_ROM[mode_reg][head_reg] == byte_reg);
    assign tail_nxt = {1'b0, tail_reg} + 4'd1;
    assign tail_nxt_hit = (tail_nxt < 4'(TAIL_LEN)) && (TAIL_ROM[tail_nxt[2:0]] == byte_reg);

    always_comb
    begin
        phase_next = phase_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cv_next    = 1'b0;
        ci_next    = '0;
        cb_next    = '0;
        dr_next    = 1'b0;
        dc_next    = MODE_AT;

        if (mode_reg == MODE_AT)
        begin
            // plain AT: tail hunt only, other state untouched
            if (tail_hit)
            begin
                if (tail_reg == 3'(TAIL_LEN - 1))
                begin
                    tail_next = '0;
                    dr_next   = 1'b1;
                end
                else
                begin
                    tail_next = tail_reg + 3'd1;
                end
            end
            else
            begin
                tail_next = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // mismatch restarts without rechecking this byte
                    if (head_hit)
                    begin
                        if ({1'b0, head_reg} == HDR_LEN[mode_reg] - HLEN_W'(1))
                        begin
                            head_next  = '0;
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            head_next = head_reg + HIDX_W'(1);
                        end
                    end
                    else
                    begin
                        head_next = '0;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (tail_hit)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else if (count_reg < COUNT_W'(MAX_PAYLOAD))
                    begin
                        cv_next    = 1'b1;
                        ci_next    = count_reg[CAPTURE_W-1:0];
                        cb_next    = byte_reg;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                PH_TAIL:
                begin
                    if (tail_nxt_hit && (tail_nxt == 4'(TAIL_LEN - 1)))
                    begin
                        dr_next    = 1'b1;
                        dc_next    = mode_reg;
                        phase_next = PH_HEADER;
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                    else if (tail_nxt_hit)
                    begin
                        tail_next = tail_nxt[2:0];
                    end
                    else
                    begin
                        // broken tail: start over
                        phase_next = PH_HEADER;
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_full_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            mode_reg <= mode;
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            cv_reg <= cv_next;
            ci_reg <= ci_next;
            cb_reg <= cb_next;
            dr_reg <= dr_next;
            dc_reg <= dc_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign capture_valid = cv_reg;
    assign capture_index = ci_reg;
    assign capture_byte  = cb_reg;
    assign done_res      = dr_reg;
    assign done_command  = dc_reg;

    // a completion never carries a payload byte
    a_done_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> !capture_valid)
        else $error("done_res together with capture_valid");

    // idle result fields are zero
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !capture_valid |-> capture_index == '0 && capture_byte == '0)
        else $error("capture fields set without capture_valid");

    // payload count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond capacity");

    // state only moves when a transaction is handed to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(count_reg) && $stable(head_reg))
        else $error("parse state changed without a transaction");

endmodule
